@@ design/mrsd_pkg.sv @@
// Package for the modem rate-signal detector: configuration types, register
// indexes, reset values and the rate priority function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrsd_pkg;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_R   = 2'd1,
    MODE_E   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_MASK     = 2'd1,
    REG_EXPECTED = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    RATE_QPSK   = 3'd0,
    RATE_QAM16  = 3'd1,
    RATE_QAM32  = 3'd2,
    RATE_QAM64  = 3'd3,
    RATE_QAM128 = 3'd4
  } rate_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] mask;
    logic [15:0] expected;
  } cfg_t;

  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [1:0]  MODE_RESET = 2'd0;
  localparam logic [15:0] MASK_RESET = 16'h8888;
  localparam logic [15:0] EXPECTED_RESET = 16'h8880;
  localparam logic [15:0] WINDOW_RESET = 16'hFFFF;
  localparam logic [2:0]  SKIP_AFTER_FIRST = 3'd7;

  function automatic logic [2:0] rate_of(input logic [15:0] w);
    logic [2:0] r;
    if (w[3]) begin
      r = RATE_QAM128;
    end else if (w[5]) begin
      r = RATE_QAM64;
    end else if (w[9]) begin
      r = RATE_QAM32;
    end else if (w[6]) begin
      r = RATE_QAM16;
    end else begin
      r = RATE_QPSK;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/modem_rate_signal_detector.sv @@
// Top level of the modem rate-signal detector: input register, step logic,
// result register. Depends on mrsd_pkg, mrsd_cfg and mrsd_core.
//
//   channel  signals                     direction  payload
//   in       in_valid / in_ready         sink       dibit
//   out      out_valid / out_ready       source     detected, rate_code
//   cfg      cfg_we                      sink       cfg_addr, cfg_data
//
// One dibit per cycle while out_ready holds; input register, then result.
// The step runs from the input register straight into the result register.
// Reset (synchronous, rst high) empties both registers and restores state.
// A stalled result holds; the input register still takes one more transaction.
`timescale 1ns / 1ps
`default_nettype none

module modem_rate_signal_detector (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [1:0]                      cfg_addr,
  input  wire logic [mrsd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      dibit,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 detected,
  output logic [2:0]                           rate_code
);

  mrsd_pkg::cfg_t cfg;
  logic       in_reg_valid;
  logic [1:0] in_reg_dibit;
  logic       advance;
  logic       hit;
  logic [2:0] rate_next;

  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  mrsd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  mrsd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .dibit     (in_reg_dibit),
    .cfg       (cfg),
    .hit       (hit),
    .rate_next (rate_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_reg_dibit <= dibit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      detected  <= hit;
      rate_code <= rate_next;
    end
  end

endmodule

`default_nettype wire

@@ design/mrsd_cfg.sv @@
// Configuration registers of the modem rate-signal detector.
// Depends on mrsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrsd_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_addr,
  input  wire logic [mrsd_pkg::CFG_DATA_W-1:0] cfg_data,
  output mrsd_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= mrsd_pkg::MODE_RESET;
      cfg.mask     <= mrsd_pkg::MASK_RESET;
      cfg.expected <= mrsd_pkg::EXPECTED_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        mrsd_pkg::REG_MODE:     cfg.mode     <= cfg_data[1:0];
        mrsd_pkg::REG_MASK:     cfg.mask     <= cfg_data;
        mrsd_pkg::REG_EXPECTED: cfg.expected <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/mrsd_core.sv @@
// Detection state and per-dibit step logic: window, candidate word, skip
// counter and held rate. Depends on mrsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrsd_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire logic [1:0]     dibit,
  input  wire mrsd_pkg::cfg_t cfg,
  output logic                hit,
  output logic [2:0]          rate_next
);

  logic [15:0] window;
  logic [15:0] window_next;
  logic [15:0] candidate;
  logic [15:0] candidate_next;
  logic [2:0]  skip_count;
  logic [2:0]  skip_count_next;
  logic [2:0]  held_rate;
  logic [15:0] shifted;

  always_comb begin
    shifted         = {window[13:0], dibit};
    window_next     = shifted;
    candidate_next  = candidate;
    skip_count_next = skip_count;
    rate_next       = held_rate;
    hit             = 1'b0;
    case (cfg.mode)
      mrsd_pkg::MODE_R: begin
        if (skip_count != 3'd0) begin
          skip_count_next = skip_count - 3'd1;
        end else if ((shifted & cfg.mask) == cfg.expected) begin
          if (shifted == candidate) begin
            rate_next   = mrsd_pkg::rate_of(shifted);
            window_next = 16'd0;
            hit         = 1'b1;
          end else begin
            candidate_next  = shifted;
            skip_count_next = mrsd_pkg::SKIP_AFTER_FIRST;
          end
        end else begin
          candidate_next = 16'd0;
        end
      end
      mrsd_pkg::MODE_E: begin
        hit = ((shifted & cfg.mask) == cfg.mask);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= mrsd_pkg::WINDOW_RESET;
      candidate  <= 16'd0;
      skip_count <= 3'd0;
      held_rate  <= 3'd0;
    end else if (step) begin
      window     <= window_next;
      candidate  <= candidate_next;
      skip_count <= skip_count_next;
      held_rate  <= rate_next;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_pair: assert property (@(posedge clk) disable iff (rst)
    step && hit && (cfg.mode == mrsd_pkg::MODE_R) |=> window == 16'd0)
    else $error("window not cleared after R pair");

  a_skip_counts_down: assert property (@(posedge clk) disable iff (rst)
    step && (cfg.mode == mrsd_pkg::MODE_R) && (skip_count != 3'd0)
    |=> skip_count == 3'($past(skip_count) - 3'd1))
    else $error("skip counter did not count down");

  a_candidate_held_in_skip: assert property (@(posedge clk) disable iff (rst)
    step && (skip_count != 3'd0) |=> candidate == $past(candidate))
    else $error("candidate changed while skipping");

  a_rate_in_range: assert property (@(posedge clk) disable iff (rst)
    held_rate <= mrsd_pkg::RATE_QAM128)
    else $error("held rate out of range");
`endif

endmodule

`default_nettype wire
